>>> rtl/core/nqse_pkg.sv
`default_nettype none

package nqse_pkg;

    // Width of the row and column fields of a result transaction.
    localparam int FIELD_W = 5;

    // Input and output tdata widths, padded to whole bytes.
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 16;

    // Reset value of the board size register.
    localparam logic [FIELD_W-1:0] BOARD_SIZE_RST = 5'd8;

    // Operation applied by the stack cells at a clock edge.
    typedef enum logic [1:0] {
        OP_HOLD = 2'b00,
        OP_PUSH = 2'b01,
        OP_POP  = 2'b10,
        OP_LOAD = 2'b11
    } stack_op_t;

endpackage

`default_nettype wire

>>> rtl/core/n_queens_solution_enumerator.sv
// Operation: a request is taken, then the search steps (a step places a
// queen or backs up one row), then the results follow, held by any m_tready stall.
// A new request is taken only once the block is back in idle; one made after
// exhaustion is answered with the done item without a search.
// Reset: rst_n clears the control state and sets board_size to 8; the stack
// contents are undefined until a search writes them.
`default_nettype none

module n_queens_solution_enumerator
    import nqse_pkg::*;
#(
    parameter int MAX_SIZE = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Configuration write channel: board_size.
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [FIELD_W-1:0]    cfg_data,
    // Request stream.
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // [0] restart, [7:1] zero
    // Result stream.
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,   // [4:0] row, [9:5] column, [15:10] zero
    output logic                       m_tlast,
    output logic                       m_tuser    // [0] done_res
);

    localparam int W     = MAX_SIZE;
    localparam int E_W   = 4 * W;
    localparam int SZ_W  = $clog2(MAX_SIZE + 1);
    localparam int IDX_W = $clog2(MAX_SIZE);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SEARCH = 4'b0010,
        ST_EMIT   = 4'b0100,
        ST_DONE   = 4'b1000
    } state_t;

    // Binary index of the set bit in a one-hot mask.
    function automatic logic [SZ_W-1:0] onehot_to_bin(input logic [W-1:0] oh);
        logic [SZ_W-1:0] res;
        res = '0;
        for (int i = 0; i < W; i++)
        begin
            if (oh[i])
            begin
                res = res | SZ_W'(i);
            end
        end
        return res;
    endfunction

    // Control registers.
    state_t             state_reg, state_next;
    logic [FIELD_W-1:0] board_size_reg, board_size_next;
    logic [SZ_W-1:0]    row_reg, row_next;
    logic               started_reg, started_next;
    logic               exhausted_reg, exhausted_next;
    logic [IDX_W-1:0]   emit_idx_reg, emit_idx_next;

    // Output register.
    logic               out_valid_reg;
    logic [FIELD_W-1:0] out_row_reg;
    logic [FIELD_W-1:0] out_col_reg;
    logic               out_last_reg;
    logic               out_done_reg;

    logic               out_load;
    logic [FIELD_W-1:0] out_row_val;
    logic [FIELD_W-1:0] out_col_val;
    logic               out_last_val;
    logic               out_done_val;

    // Stack signals.
    stack_op_t          op;
    logic [E_W-1:0]     ent [MAX_SIZE];
    logic [E_W-1:0]     load_val;
    logic [E_W-1:0]     child;
    logic [E_W-1:0]     head_placed;
    logic [W-1:0]       h_cols, h_ld, h_rd, h_q;
    logic [W-1:0]       higher, avail, pick, board_mask;
    logic [SZ_W-1:0]    n_eff;
    logic               fresh;
    logic [W-1:0]       q_sel;

    // Effective board size: zero is treated as one, anything above the
    // maximum as the maximum.
    always_comb
    begin
        if (board_size_reg == '0)
        begin
            n_eff = SZ_W'(1);
        end
        else if (board_size_reg > FIELD_W'(MAX_SIZE))
        begin
            n_eff = SZ_W'(MAX_SIZE);
        end
        else
        begin
            n_eff = board_size_reg[SZ_W-1:0];
        end
    end

    always_comb
    begin
        for (int i = 0; i < W; i++)
        begin
            board_mask[i] = (SZ_W'(i) < n_eff);
        end
    end

    // The head cell always describes the row being searched.
    assign h_cols = ent[0][4*W-1:3*W];
    assign h_ld   = ent[0][3*W-1:2*W];
    assign h_rd   = ent[0][2*W-1:W];
    assign h_q    = ent[0][W-1:0];

    // Only columns beyond the one last tried in this row remain candidates.
    assign higher = (h_q == '0) ? '1 : ~(h_q | (h_q - W'(1)));
    assign avail  = ~(h_cols | h_ld | h_rd) & board_mask & higher;
    assign pick   = avail & (~avail + W'(1));

    // Entry for the row below: the diagonals move one column per row.
    assign child       = {h_cols | pick, (h_ld | pick) << 1, (h_rd | pick) >> 1, {W{1'b0}}};
    assign head_placed = {h_cols, h_ld, h_rd, pick};

    assign fresh = s_tdata[0] || !started_reg;

    // Row r of the current placement sits in cell n - r.
    assign q_sel = ent[emit_idx_reg][W-1:0];

    // Chain of stack cells: a push moves every entry one cell deeper, a pop
    // brings every entry one cell back towards the head.
    for (genvar g = 0; g < MAX_SIZE; g++)
    begin : g_cell
        logic [E_W-1:0] up_w;
        logic [E_W-1:0] down_w;

        if (g == 0)
        begin : g_up_head
            assign up_w = child;
        end
        else if (g == 1)
        begin : g_up_first
            assign up_w = head_placed;
        end
        else
        begin : g_up_rest
            assign up_w = ent[g-1];
        end

        if (g == MAX_SIZE - 1)
        begin : g_down_tail
            assign down_w = '0;
        end
        else
        begin : g_down_rest
            assign down_w = ent[g+1];
        end

        nqse_cell #(
            .W       (W),
            .IS_HEAD (g == 0)
        ) u_cell (
            .clk     (clk),
            .op      (op),
            .up_in   (up_w),
            .down_in (down_w),
            .load_in (load_val),
            .ent_out (ent[g])
        );
    end

    // Sequencer: takes a request, steps the search one placement or one
    // backtrack per cycle, then streams the solution or the done item.
    always_comb
    begin
        state_next      = state_reg;
        board_size_next = board_size_reg;
        row_next        = row_reg;
        started_next    = started_reg;
        exhausted_next  = exhausted_reg;
        emit_idx_next   = emit_idx_reg;
        op              = OP_HOLD;
        load_val        = head_placed;
        out_load        = 1'b0;
        out_row_val     = '0;
        out_col_val     = '0;
        out_last_val    = 1'b0;
        out_done_val    = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    started_next = 1'b1;
                    if (fresh)
                    begin
                        exhausted_next = 1'b0;
                        op             = OP_LOAD;
                        load_val       = '0;
                        row_next       = SZ_W'(1);
                        state_next     = ST_SEARCH;
                    end
                    else if (exhausted_reg)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SEARCH;
                    end
                end
            end

            ST_SEARCH:
            begin
                if (avail != '0)
                begin
                    if (row_reg == n_eff)
                    begin
                        op            = OP_LOAD;
                        load_val      = head_placed;
                        emit_idx_next = IDX_W'(n_eff - SZ_W'(1));
                        state_next    = ST_EMIT;
                    end
                    else
                    begin
                        op       = OP_PUSH;
                        row_next = row_reg + SZ_W'(1);
                    end
                end
                else if (row_reg == SZ_W'(1))
                begin
                    exhausted_next = 1'b1;
                    state_next     = ST_DONE;
                end
                else
                begin
                    op       = OP_POP;
                    row_next = row_reg - SZ_W'(1);
                end
            end

            ST_EMIT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_load     = 1'b1;
                    out_row_val  = FIELD_W'(n_eff - SZ_W'(emit_idx_reg));
                    out_col_val  = FIELD_W'(onehot_to_bin(q_sel)) + FIELD_W'(1);
                    out_last_val = (emit_idx_reg == '0);
                    if (emit_idx_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        emit_idx_next = emit_idx_reg - IDX_W'(1);
                    end
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_load     = 1'b1;
                    out_last_val = 1'b1;
                    out_done_val = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
        endcase

        // A size write makes the next request start anew; a running search goes on.
        if (cfg_valid)
        begin
            board_size_next = cfg_data;
            started_next    = 1'b0;
            exhausted_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            board_size_reg <= BOARD_SIZE_RST;
            row_reg        <= SZ_W'(1);
            started_reg    <= 1'b0;
            exhausted_reg  <= 1'b0;
            emit_idx_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            board_size_reg <= board_size_next;
            row_reg        <= row_next;
            started_reg    <= started_next;
            exhausted_reg  <= exhausted_next;
            emit_idx_reg   <= emit_idx_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_row_reg  <= out_row_val;
            out_col_reg  <= out_col_val;
            out_last_reg <= out_last_val;
            out_done_reg <= out_done_val;
        end
    end

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(OUT_DATA_W - 2*FIELD_W){1'b0}}, out_col_reg, out_row_reg};
    assign m_tlast   = out_last_reg;
    assign m_tuser   = out_done_reg;

    // The search row never leaves the board.
    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> (row_reg >= SZ_W'(1) && row_reg <= n_eff))
        else $error("search row outside the board");

    // A solution is only streamed once the last row has been filled.
    a_emit_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (row_reg == n_eff))
        else $error("solution streamed before the last row was placed");

    // The done item ends its response and carries no coordinates.
    a_done_item: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tlast && m_tdata == '0))
        else $error("malformed done transaction");

    // Exhaustion can only follow a search that was started.
    a_exhaust: assert property (@(posedge clk) disable iff (!rst_n)
        exhausted_reg |-> started_reg)
        else $error("exhausted without a started search");

endmodule

`default_nettype wire

>>> rtl/core/nqse_cell.sv
`default_nettype none

// One level of the placement stack. An entry holds the column, left diagonal
// and right diagonal attack masks seen by its row, and the one-hot column
// placed (or last tried) in that row.
module nqse_cell
    import nqse_pkg::*;
#(
    parameter int W       = 16,
    parameter bit IS_HEAD = 1'b0
)
(
    input  wire logic           clk,
    input  wire stack_op_t      op,
    input  wire logic [4*W-1:0] up_in,
    input  wire logic [4*W-1:0] down_in,
    input  wire logic [4*W-1:0] load_in,
    output logic      [4*W-1:0] ent_out
);

    logic [4*W-1:0] ent_reg;
    logic [4*W-1:0] ent_next;

    always_comb
    begin
        ent_next = ent_reg;
        unique case (op)
            OP_HOLD: ent_next = ent_reg;
            OP_PUSH: ent_next = up_in;
            OP_POP:  ent_next = down_in;
            OP_LOAD: ent_next = IS_HEAD ? load_in : ent_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    assign ent_out = ent_reg;

endmodule

`default_nettype wire

>>> tb/sv/n_queens_solution_enumerator_tb.sv
`default_nettype none

module n_queens_solution_enumerator_tb;

    import nqse_pkg::*;

    localparam int BOARD_MAX   = 16;
    // Cycles with no transaction on any channel before the run is abandoned.
    // It is meant to leave a wide margin over any correct response, including
    // the search for the first placement on the largest board.
    localparam int QUIET_LIMIT = 1_000_000;
    localparam int RANDOM_REQS = 200;

    // One request waiting to be driven. A request marked drain_first is held
    // back until every queen of the earlier requests has been received.
    typedef struct {
        bit restart;
        bit drain_first;
    } request_t;

    // One queen placement (or the done marker) as the block should return it.
    typedef struct packed {
        logic [FIELD_W-1:0] row;
        logic [FIELD_W-1:0] column;
        logic               last;
        logic               done;
    } queen_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [FIELD_W-1:0]    cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;    // [0] restart, [7:1] zero
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;           // [4:0] row, [9:5] column, [15:10] zero
    logic                  m_tlast;
    logic                  m_tuser;           // [0] done_res

    request_t pending_requests[$];
    queen_t   due_queens[$];

    int  reqs_queued = 0;
    int  reqs_taken  = 0;
    int  results_seen = 0;
    int  mismatches  = 0;
    int  quiet_cycles = 0;
    int  req_gap     = 0;
    int  res_stall   = 0;
    bit  req_fire    = 1'b0;
    bit  res_fire    = 1'b0;
    // When set, neither side inserts idle cycles.
    bit  tight_flow  = 1'b0;

    // The testbench's own copy of the search state.
    logic [FIELD_W-1:0] size_reg = BOARD_SIZE_RST;
    logic [FIELD_W-1:0] placed_col [BOARD_MAX];
    int                 resume_row   = 1;
    bit                 search_live  = 1'b0;
    bit                 search_spent = 1'b0;

    n_queens_solution_enumerator #(
        .MAX_SIZE (BOARD_MAX)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Search predictor
    // ------------------------------------------------------------------

    // A size of 0 behaves as 1 and anything above the maximum as the maximum.
    function automatic int board_in_use(logic [FIELD_W-1:0] value);
        if (value == 0)
        begin
            return 1;
        end
        if (int'(value) > BOARD_MAX)
        begin
            return BOARD_MAX;
        end
        return int'(value);
    endfunction

    // True when no queen in rows 1 to row-1 shares the column or a diagonal.
    function automatic bit square_free(int row, int col);
        int c;
        int dr;
        int dc;
        for (int k = 1; k < row; k++)
        begin
            c  = int'(placed_col[k-1]);
            dr = row - k;
            dc = (c > col) ? (c - col) : (col - c);
            if (c == col || dr == dc)
            begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Depth-first walk to the next full placement. Resumes from the last
    // solution unless a fresh search is asked for. False once every placement
    // has been visited.
    function automatic bit next_placement(int n, bit fresh);
        int row;
        int col;
        if (fresh)
        begin
            row = 1;
            col = 1;
        end
        else
        begin
            row = resume_row;
            if (row < 1 || row > n)
            begin
                return 1'b0;
            end
            col = int'(placed_col[row-1]) + 1;
        end
        while (1'b1)
        begin
            if (col > n)
            begin
                // Every column of this row is used up, so back up one row.
                row--;
                if (row == 0)
                begin
                    return 1'b0;
                end
                col = int'(placed_col[row-1]) + 1;
            end
            else if (square_free(row, col))
            begin
                placed_col[row-1] = FIELD_W'(col);
                if (row == n)
                begin
                    resume_row = row;
                    return 1'b1;
                end
                row++;
                col = 1;
            end
            else
            begin
                col++;
            end
        end
        return 1'b0;
    endfunction

    // Works out the whole response to one request and queues it.
    function automatic void solve_next(bit restart);
        int     n;
        bit     fresh;
        queen_t q;
        n     = board_in_use(size_reg);
        fresh = 1'b0;
        // A request with no search in progress starts one, as a restart does.
        if (restart || !search_live)
        begin
            search_live  = 1'b1;
            search_spent = 1'b0;
            resume_row   = 1;
            fresh        = 1'b1;
        end
        if (!search_spent)
        begin
            if (next_placement(n, fresh))
            begin
                for (int r = 1; r <= n; r++)
                begin
                    q.row    = FIELD_W'(r);
                    q.column = placed_col[r-1];
                    q.last   = (r == n);
                    q.done   = 1'b0;
                    due_queens.push_back(q);
                end
                return;
            end
            search_spent = 1'b1;
            resume_row   = 1;
        end
        // Exhausted (or no solution at all): a single done transaction,
        // repeated for every request until a restart or a size write.
        q.row    = '0;
        q.column = '0;
        q.last   = 1'b1;
        q.done   = 1'b1;
        due_queens.push_back(q);
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Acceptance is recorded at the rising edge; the prediction is made at
    // the same edge, so it is always in place before any result can follow.
    always @(posedge clk)
    begin : request_capture
        req_fire <= s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
        begin
            solve_next(s_tdata[0]);
            reqs_taken++;
        end
    end

    // Drives at the falling edge. A transaction is held until it is accepted;
    // after that the drawn gap runs out before the next one is presented.
    always @(negedge clk)
    begin : request_driver
        if (rst_n && (!s_tvalid || req_fire))
        begin
            if (req_gap > 0)
            begin
                req_gap--;
                s_tvalid <= 1'b0;
            end
            else if (pending_requests.size() > 0 &&
                     !(pending_requests[0].drain_first && due_queens.size() != 0))
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= {{(IN_DATA_W-1){1'b0}}, pending_requests[0].restart};
                pending_requests.pop_front();
                req_gap = tight_flow ? 0 : $urandom_range(0, 11);
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    always @(negedge clk)
    begin : result_sink
        if (res_fire)
        begin
            res_stall = tight_flow ? 0 : $urandom_range(0, 11);
        end
        if (res_stall > 0)
        begin
            res_stall--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : result_check
        queen_t got;
        queen_t want;
        res_fire <= m_tvalid && m_tready;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.row    = m_tdata[FIELD_W-1:0];
            got.column = m_tdata[2*FIELD_W-1:FIELD_W];
            got.last   = m_tlast;
            got.done   = m_tuser;
            results_seen++;
            if (due_queens.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected result %0d: row %0d column %0d last %0b done %0b",
                             results_seen, got.row, got.column, got.last, got.done);
                end
            end
            else
            begin
                want = due_queens.pop_front();
                if (got.row != want.row || got.column != want.column ||
                    got.last != want.last || got.done != want.done)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("result %0d: expected row %0d column %0d last %0b done %0b",
                                 results_seen, want.row, want.column, want.last, want.done);
                        $display("result %0d:      got row %0d column %0d last %0b done %0b",
                                 results_seen, got.row, got.column, got.last, got.done);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: any transaction on any channel counts as progress.
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin : watchdog
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("** n_queens_solution_enumerator: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    task automatic queue_request(bit restart, bit drain_first);
        request_t req;
        req.restart     = restart;
        req.drain_first = drain_first;
        pending_requests.push_back(req);
        reqs_queued++;
    endtask

    // Waits until every queued request has been taken and answered in full.
    task automatic wait_drained();
        while (!(reqs_taken == reqs_queued && due_queens.size() == 0))
        begin
            @(posedge clk);
        end
    endtask

    // Every request yields at least one transaction, so once the last one has
    // arrived the block is idle; a short pause covers its return to idle.
    task automatic write_board(logic [FIELD_W-1:0] value);
        wait_drained();
        repeat (8) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        // Any size write abandons the search in progress.
        size_reg     = value;
        search_live  = 1'b0;
        search_spent = 1'b0;
        resume_row   = 1;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        int          pick;
        int          reps;
        int          heavy;
        int          random_items;
        bit          walked_seven;
        logic [FIELD_W-1:0] size;

        foreach (placed_col[i])
        begin
            placed_col[i] = '0;
        end
        heavy        = 0;
        random_items = 0;
        walked_seven = 1'b0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Default size of 8 with no search yet: a plain request must start
        // one, a restart goes back to the first placement.
        queue_request(1'b0, 1'b0);
        queue_request(1'b1, 1'b0);
        queue_request(1'b0, 1'b0);
        queue_request(1'b0, 1'b0);

        // One queen: a single solution, then done repeatedly, then a restart.
        write_board(5'd1);
        queue_request(1'b0, 1'b0);
        queue_request(1'b0, 1'b0);
        queue_request(1'b0, 1'b0);
        queue_request(1'b1, 1'b0);

        // Boards of two and three have no solution at all.
        write_board(5'd2);
        queue_request(1'b0, 1'b0);
        queue_request(1'b1, 1'b0);
        write_board(5'd3);
        queue_request(1'b0, 1'b0);
        queue_request(1'b0, 1'b0);

        // A size of zero behaves as one.
        write_board(5'd0);
        queue_request(1'b1, 1'b0);
        queue_request(1'b0, 1'b0);

        // Four queens: both solutions, exhaustion, a repeat of done, restart.
        write_board(5'd4);
        queue_request(1'b0, 1'b0);
        queue_request(1'b0, 1'b0);
        queue_request(1'b0, 1'b0);
        queue_request(1'b0, 1'b0);
        queue_request(1'b1, 1'b0);

        // The largest board, and an oversized value that is clipped to it.
        // The last request here waits for the board to drain first.
        write_board(5'd16);
        queue_request(1'b0, 1'b0);
        queue_request(1'b0, 1'b0);
        write_board(5'd31);
        queue_request(1'b1, 1'b0);
        queue_request(1'b0, 1'b1);

        // Random phases. Most use modest boards so that long runs of plain
        // requests walk deep into the search and often exhaust it; large
        // boards are rare because their first placement is costly.
        while (random_items < RANDOM_REQS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
            begin
                size = FIELD_W'($urandom_range(1, 3));
            end
            else if (pick < 70)
            begin
                size = FIELD_W'($urandom_range(4, 8));
            end
            else if (pick < 88)
            begin
                size = FIELD_W'($urandom_range(9, 12));
            end
            else if (pick < 96)
            begin
                size = (heavy < 2) ? FIELD_W'($urandom_range(13, 16)) : 5'd6;
            end
            else if ($urandom_range(0, 1) == 0)
            begin
                size = 5'd0;
            end
            else
            begin
                size = (heavy < 2) ? FIELD_W'($urandom_range(17, 31)) : 5'd5;
            end

            if (board_in_use(size) >= 13)
            begin
                heavy++;
                reps = $urandom_range(2, 5);
            end
            else if (size == 5'd7 && !walked_seven)
            begin
                // Forty solutions and then done: walk the whole search once.
                walked_seven = 1'b1;
                reps = 44;
            end
            else
            begin
                reps = $urandom_range(4, 18);
            end

            write_board(size);
            tight_flow = ($urandom_range(0, 3) == 0);
            repeat (reps)
            begin
                queue_request($urandom_range(0, 11) == 0, $urandom_range(0, 24) == 0);
                random_items++;
            end
        end

        wait_drained();
        repeat (40) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("** n_queens_solution_enumerator: PASSED **");
        end
        else
        begin
            $display("** n_queens_solution_enumerator: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
rtl/core/nqse_pkg.sv
rtl/core/nqse_cell.sv
rtl/core/n_queens_solution_enumerator.sv
tb/sv/n_queens_solution_enumerator_tb.sv
